// ===== sv/sptb_pkg.sv =====
// ----------------------------------------------------------------------------
// sptb_pkg
// shared sizes, types and codes of the sv39 page table builder
// ----------------------------------------------------------------------------
package sptb_pkg;

   localparam int TABLE_PAGES = 64;
   localparam int ENTRIES     = 512;
   localparam int IDX_W       = 9;
   localparam int PAGE_W      = $clog2(TABLE_PAGES);
   localparam int ADDR_W      = PAGE_W + IDX_W;
   localparam int POOL_WORDS  = TABLE_PAGES * ENTRIES;
   localparam int CNT_W       = $clog2(TABLE_PAGES + 1);
   localparam int PPN_W       = 44;
   localparam int WORD_W      = 64;
   localparam int PERM_W      = 8;
   localparam int VA_W        = 27;
   localparam int RTAB_W      = 6;
   localparam int STATUS_W    = 2;
   localparam int ADDED_W     = 2;

   localparam logic [PPN_W-1:0]  BASE_RESET = 44'd524288;
   localparam logic [PERM_W-1:0] PTE_V      = 8'h01;
   localparam logic [PERM_W-1:0] PTE_U      = 8'h10;

   localparam logic OP_MAP  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [PAGE_W-1:0] page_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [PPN_W-1:0]  ppn_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_POOL_EMPTY = 2'd1,
      ST_OUTSIDE    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ASEL_CLEAR = 3'd0,
      ASEL_ROOT  = 3'd1,
      ASEL_MID   = 3'd2,
      ASEL_LEAF  = 3'd3,
      ASEL_WORD  = 3'd4
   } asel_type;

   typedef struct packed {
      logic     latch;
      logic     clear_wr;
      asel_type asel;
      logic     chk_root;
      logic     chk_mid;
      logic     wr_leaf;
      logic     cap_word;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic fault;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/sv39_page_table_builder_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_builder_core
// builds a three level sv39 page table in an internal pool of table pages
// ----------------------------------------------------------------------------
// map word: root read and check, mid read and check, leaf write, then the result
//    (ends early on an error); three dependent reads and writes through one ram
// read word: the entry is read from the ram and captured, then given as the result;
//    one word in work at a time, a result held by rsp_ready delays the next
// reset: pool cleared one entry a cycle, TABLE_PAGES*512 entries (32768),
//    no word accepted meanwhile; csr writes are taken throughout
module sv39_page_table_builder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [sptb_pkg::VA_W-1:0]     req_va_page,
   input  logic [sptb_pkg::PPN_W-1:0]    req_pa_page,
   input  logic [sptb_pkg::PERM_W-1:0]   req_perm,
   input  logic                          req_last_page,
   input  logic [sptb_pkg::RTAB_W-1:0]   req_read_table,
   input  logic [sptb_pkg::IDX_W-1:0]    req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sptb_pkg::STATUS_W-1:0] rsp_status,
   output logic [sptb_pkg::WORD_W-1:0]   rsp_entry_value,
   output logic [sptb_pkg::ADDED_W-1:0]  rsp_tables_added,
   output logic                          rsp_region_end,
   input  logic                          csr_we,
   input  logic [sptb_pkg::PPN_W-1:0]    csr_wdata
);

   sptb_pkg::cmd_type cmd;
   sptb_pkg::sts_type sts;

   sptb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sptb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_va_page      (req_va_page),
      .req_pa_page      (req_pa_page),
      .req_perm         (req_perm),
      .req_last_page    (req_last_page),
      .req_read_table   (req_read_table),
      .req_read_index   (req_read_index),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_tables_added (rsp_tables_added),
      .rsp_region_end   (rsp_region_end)
   );

endmodule

// ===== sv/sptb_ram.sv =====
// ----------------------------------------------------------------------------
// sptb_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module sptb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/sptb_dp.sv =====
// ----------------------------------------------------------------------------
// sptb_dp
// datapath: table pool, page allocator, pointer checks and result register
// ----------------------------------------------------------------------------
module sptb_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sptb_pkg::VA_W-1:0]    req_va_page,
   input  logic [sptb_pkg::PPN_W-1:0]   req_pa_page,
   input  logic [sptb_pkg::PERM_W-1:0]  req_perm,
   input  logic                         req_last_page,
   input  logic [sptb_pkg::RTAB_W-1:0]  req_read_table,
   input  logic [sptb_pkg::IDX_W-1:0]   req_read_index,
   input  logic                         csr_we,
   input  logic [sptb_pkg::PPN_W-1:0]   csr_wdata,
   input  sptb_pkg::cmd_type            cmd,
   output sptb_pkg::sts_type            sts,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [sptb_pkg::STATUS_W-1:0] rsp_status,
   output logic [sptb_pkg::WORD_W-1:0]  rsp_entry_value,
   output logic [sptb_pkg::ADDED_W-1:0] rsp_tables_added,
   output logic                         rsp_region_end
);

   sptb_pkg::ppn_type                base_ff, base_in;
   sptb_pkg::cnt_type                piu_ff, piu_in;
   sptb_pkg::addr_type               clr_ff, clr_in;
   logic [sptb_pkg::VA_W-1:0]        va_ff, va_in;
   sptb_pkg::ppn_type                pa_ff, pa_in;
   logic [sptb_pkg::PERM_W-1:0]      perm_ff, perm_in;
   logic                             last_ff, last_in;
   logic [sptb_pkg::RTAB_W-1:0]      rtab_ff, rtab_in;
   sptb_pkg::idx_type                ridx_ff, ridx_in;
   sptb_pkg::page_type               pg_ff, pg_in;
   sptb_pkg::status_type             status_ff, status_in;
   sptb_pkg::word_type               value_ff, value_in;
   logic [sptb_pkg::ADDED_W-1:0]     added_ff, added_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sptb_pkg::status_type             rsp_status_ff, rsp_status_in;
   sptb_pkg::word_type               rsp_value_ff, rsp_value_in;
   logic [sptb_pkg::ADDED_W-1:0]     rsp_added_ff, rsp_added_in;
   logic                             rsp_end_ff, rsp_end_in;

   sptb_pkg::idx_type                i2, i1, i0;
   sptb_pkg::addr_type               ram_addr;
   logic                             ram_we;
   sptb_pkg::word_type               ram_wdata;
   sptb_pkg::word_type               ram_rdata;
   logic                             checking;
   logic                             need_alloc;
   logic                             full;
   sptb_pkg::ppn_type                new_ppn;
   sptb_pkg::ppn_type                rel;
   logic                             outside;
   logic                             fault;
   logic [sptb_pkg::PERM_W-1:0]      flags;
   sptb_pkg::word_type               alloc_word;
   sptb_pkg::word_type               leaf_word;
   logic                             rtab_oob;

   assign i2 = va_ff[26:18];
   assign i1 = va_ff[17:9];
   assign i0 = va_ff[8:0];

   // pointer check and allocation of one walk level
   assign checking   = cmd.chk_root | cmd.chk_mid;
   assign need_alloc = ~ram_rdata[0];
   assign full       = (piu_ff == sptb_pkg::CNT_W'(sptb_pkg::TABLE_PAGES));
   assign new_ppn    = base_ff + sptb_pkg::PPN_W'(piu_ff);
   assign rel        = ram_rdata[53:10] - base_ff;
   assign outside    = (rel >= sptb_pkg::PPN_W'(sptb_pkg::TABLE_PAGES));
   assign fault      = need_alloc ? full : outside;
   assign flags      = cmd.chk_root ? sptb_pkg::PTE_V
                                    : (perm_ff & (sptb_pkg::PTE_U | sptb_pkg::PTE_V));
   assign alloc_word = {10'd0, new_ppn, 2'd0, flags};
   assign leaf_word  = {10'd0, pa_ff, 2'd0, perm_ff};
   assign rtab_oob   = (32'(rtab_ff) >= 32'(sptb_pkg::TABLE_PAGES));

   always_comb begin
      case (cmd.asel)
         sptb_pkg::ASEL_CLEAR: ram_addr = clr_ff;
         sptb_pkg::ASEL_ROOT:  ram_addr = {sptb_pkg::PAGE_W'(0), i2};
         sptb_pkg::ASEL_MID:   ram_addr = {pg_ff, i1};
         sptb_pkg::ASEL_LEAF:  ram_addr = {pg_ff, i0};
         sptb_pkg::ASEL_WORD:  ram_addr = {sptb_pkg::page_type'(rtab_ff), ridx_ff};
         default:              ram_addr = clr_ff;
      endcase
   end

   assign ram_we = cmd.clear_wr | (checking & need_alloc & ~full) | cmd.wr_leaf;

   always_comb begin
      if (cmd.clear_wr) begin
         ram_wdata = '0;
      end else if (cmd.wr_leaf) begin
         ram_wdata = leaf_word;
      end else begin
         ram_wdata = alloc_word;
      end
   end

   sptb_ram #(
      .WIDTH (sptb_pkg::WORD_W),
      .DEPTH (sptb_pkg::POOL_WORDS)
   ) u_pool (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      base_in       = base_ff;
      piu_in        = piu_ff;
      clr_in        = clr_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      perm_in       = perm_ff;
      last_in       = last_ff;
      rtab_in       = rtab_ff;
      ridx_in       = ridx_ff;
      pg_in         = pg_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      added_in      = added_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_added_in  = rsp_added_ff;
      rsp_end_in    = rsp_end_ff;

      if (csr_we) begin
         base_in = csr_wdata;
      end
      if (cmd.clear_wr) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.latch) begin
         va_in     = req_va_page;
         pa_in     = req_pa_page;
         perm_in   = req_perm;
         last_in   = req_last_page;
         rtab_in   = req_read_table;
         ridx_in   = req_read_index;
         status_in = sptb_pkg::ST_OK;
         value_in  = '0;
         added_in  = '0;
      end
      if (checking) begin
         if (fault) begin
            status_in = need_alloc ? sptb_pkg::ST_POOL_EMPTY : sptb_pkg::ST_OUTSIDE;
         end else if (need_alloc) begin
            piu_in   = piu_ff + 1'b1;
            added_in = added_ff + 1'b1;
            pg_in    = sptb_pkg::page_type'(piu_ff);
         end else begin
            pg_in = sptb_pkg::page_type'(rel);
         end
      end
      if (cmd.wr_leaf) begin
         value_in = leaf_word;
      end
      if (cmd.cap_word) begin
         status_in = rtab_oob ? sptb_pkg::ST_OUTSIDE : sptb_pkg::ST_OK;
         value_in  = rtab_oob ? '0 : ram_rdata;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = value_ff;
         rsp_added_in  = added_ff;
         rsp_end_in    = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= sptb_pkg::BASE_RESET;
         piu_ff       <= sptb_pkg::cnt_type'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         piu_ff       <= piu_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      perm_ff       <= perm_in;
      last_ff       <= last_in;
      rtab_ff       <= rtab_in;
      ridx_ff       <= ridx_in;
      pg_ff         <= pg_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      added_ff      <= added_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_added_ff  <= rsp_added_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign sts.clear_last = (clr_ff == sptb_pkg::addr_type'(sptb_pkg::POOL_WORDS - 1));
   assign sts.fault      = fault;
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_value  = rsp_value_ff;
   assign rsp_tables_added = rsp_added_ff;
   assign rsp_region_end   = rsp_end_ff;

endmodule

// ===== sv/sptb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sptb_ctrl
// controller: pool clearing, three level walk and read sequencing
// ----------------------------------------------------------------------------
module sptb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_opcode,
   output logic              req_ready,
   input  sptb_pkg::sts_type sts,
   output sptb_pkg::cmd_type cmd
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_ROOT_RD  = 10'b0000000100,
      S_ROOT_CHK = 10'b0000001000,
      S_MID_RD   = 10'b0000010000,
      S_MID_CHK  = 10'b0000100000,
      S_LEAF_WR  = 10'b0001000000,
      S_WORD_RD  = 10'b0010000000,
      S_WORD_CAP = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.asel  = sptb_pkg::ASEL_CLEAR;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (req_opcode == sptb_pkg::OP_READ) ? S_WORD_RD : S_ROOT_RD;
            end
         end
         S_ROOT_RD: begin
            cmd.asel = sptb_pkg::ASEL_ROOT;
            state_in = S_ROOT_CHK;
         end
         S_ROOT_CHK: begin
            cmd.asel     = sptb_pkg::ASEL_ROOT;
            cmd.chk_root = 1'b1;
            state_in     = sts.fault ? S_DONE : S_MID_RD;
         end
         S_MID_RD: begin
            cmd.asel = sptb_pkg::ASEL_MID;
            state_in = S_MID_CHK;
         end
         S_MID_CHK: begin
            cmd.asel    = sptb_pkg::ASEL_MID;
            cmd.chk_mid = 1'b1;
            state_in    = sts.fault ? S_DONE : S_LEAF_WR;
         end
         S_LEAF_WR: begin
            cmd.asel    = sptb_pkg::ASEL_LEAF;
            cmd.wr_leaf = 1'b1;
            state_in    = S_DONE;
         end
         S_WORD_RD: begin
            cmd.asel = sptb_pkg::ASEL_WORD;
            state_in = S_WORD_CAP;
         end
         S_WORD_CAP: begin
            cmd.asel     = sptb_pkg::ASEL_WORD;
            cmd.cap_word = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
